/* hw/rtl/iso_duration_validator_defines.svh */
// Assertion macros for the ISO 8601 duration validator.
`ifndef ISO_DURATION_VALIDATOR_DEFINES_SVH
`define ISO_DURATION_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define ISODV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define ISODV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ISODV_ASSERT_IMPL(lbl, ante, cons)
`define ISODV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/isodv_pkg.sv */
// Types, character codes and helpers for the ISO 8601 duration validator.
`default_nettype none

package isodv_pkg;

  typedef enum logic [2:0] {
    GP_EXPECT_P,
    GP_DATE_IDLE,
    GP_DATE_DIG,
    GP_TIME_START,
    GP_TIME_IDLE,
    GP_TIME_DIG,
    GP_TIME_FRAC,
    GP_DEAD
  } gen_phase_t;

  typedef enum logic [1:0] {
    WP_START,
    WP_NEED,
    WP_DIGITS,
    WP_DONE
  } week_phase_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_last;
    logic        empty_string;
  } item_t;

  typedef struct packed {
    logic accepted;
    logic at_start;
  } status_t;

  localparam logic [6:0] CH_P     = 7'h50;
  localparam logic [6:0] CH_W     = 7'h57;
  localparam logic [6:0] CH_T     = 7'h54;
  localparam logic [6:0] CH_Y     = 7'h59;
  localparam logic [6:0] CH_M     = 7'h4D;
  localparam logic [6:0] CH_D     = 7'h44;
  localparam logic [6:0] CH_H     = 7'h48;
  localparam logic [6:0] CH_S     = 7'h53;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;

  function automatic logic is_digit(input logic [6:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  // Bit 2 flags a hit, bits 1:0 give the unit's rank.
  function automatic logic [2:0] date_index(input logic [6:0] c);
    logic [2:0] r;
    case (c)
      CH_Y:    r = 3'b100;
      CH_M:    r = 3'b101;
      CH_D:    r = 3'b110;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] time_index(input logic [6:0] c);
    logic [2:0] r;
    case (c)
      CH_H:    r = 3'b100;
      CH_M:    r = 3'b101;
      CH_S:    r = 3'b110;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/isodv_fsm.sv */
// Recognizer state and transition logic for the general and week duration forms.
`default_nettype none

module isodv_fsm (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 advance,
  input  isodv_pkg::item_t    item,
  output isodv_pkg::status_t  status
);

  isodv_pkg::gen_phase_t  gp_r, gp_nxt;
  isodv_pkg::week_phase_t wp_r, wp_nxt;
  logic [1:0]             date_prog_r, date_prog_nxt;
  logic [1:0]             time_prog_r, time_prog_nxt;
  logic                   seen_r, seen_nxt;

  isodv_pkg::gen_phase_t  gp_s;
  isodv_pkg::week_phase_t wp_s;
  logic [1:0]             date_prog_s, time_prog_s;
  logic                   seen_s;
  logic [6:0]             c;
  logic                   non_ascii;
  logic                   first;
  logic                   dig;
  logic [2:0]             didx, tidx;

  assign c         = item.code_unit[6:0];
  assign non_ascii = |item.code_unit[15:7];
  assign first     = (gp_r == isodv_pkg::GP_EXPECT_P);
  assign dig       = isodv_pkg::is_digit(c);
  assign didx      = isodv_pkg::date_index(c);
  assign tidx      = isodv_pkg::time_index(c);

  always_comb begin
    gp_s        = gp_r;
    wp_s        = wp_r;
    date_prog_s = date_prog_r;
    time_prog_s = time_prog_r;
    seen_s      = seen_r;
    if (!item.empty_string) begin
      if (non_ascii) begin
        gp_s = isodv_pkg::GP_DEAD;
        wp_s = isodv_pkg::WP_START;
      end else begin
        case (wp_r)
          isodv_pkg::WP_START: begin
            wp_s = (first && c == isodv_pkg::CH_P) ? isodv_pkg::WP_NEED : isodv_pkg::WP_START;
          end
          isodv_pkg::WP_NEED: begin
            wp_s = dig ? isodv_pkg::WP_DIGITS : isodv_pkg::WP_START;
          end
          isodv_pkg::WP_DIGITS: begin
            if (!dig) begin
              wp_s = (c == isodv_pkg::CH_W) ? isodv_pkg::WP_DONE : isodv_pkg::WP_START;
            end
          end
          default: wp_s = isodv_pkg::WP_START;
        endcase

        case (gp_r)
          isodv_pkg::GP_EXPECT_P: begin
            gp_s = (c == isodv_pkg::CH_P) ? isodv_pkg::GP_DATE_IDLE : isodv_pkg::GP_DEAD;
          end
          isodv_pkg::GP_DATE_IDLE: begin
            if (dig) begin
              gp_s = isodv_pkg::GP_DATE_DIG;
            end else if (c == isodv_pkg::CH_T) begin
              gp_s = isodv_pkg::GP_TIME_START;
            end else begin
              gp_s = isodv_pkg::GP_DEAD;
            end
          end
          isodv_pkg::GP_DATE_DIG: begin
            if (!dig) begin
              if (didx[2] && didx[1:0] >= date_prog_r) begin
                date_prog_s = didx[1:0] + 2'd1;
                seen_s      = 1'b1;
                gp_s        = isodv_pkg::GP_DATE_IDLE;
              end else begin
                gp_s = isodv_pkg::GP_DEAD;
              end
            end
          end
          isodv_pkg::GP_TIME_START, isodv_pkg::GP_TIME_IDLE: begin
            gp_s = dig ? isodv_pkg::GP_TIME_DIG : isodv_pkg::GP_DEAD;
          end
          isodv_pkg::GP_TIME_DIG, isodv_pkg::GP_TIME_FRAC: begin
            if (!dig) begin
              if (gp_r == isodv_pkg::GP_TIME_DIG && c == isodv_pkg::CH_DOT) begin
                gp_s = isodv_pkg::GP_TIME_FRAC;
              end else if (tidx[2] && tidx[1:0] >= time_prog_r) begin
                time_prog_s = tidx[1:0] + 2'd1;
                seen_s      = 1'b1;
                gp_s        = isodv_pkg::GP_TIME_IDLE;
              end else begin
                gp_s = isodv_pkg::GP_DEAD;
              end
            end
          end
          default: gp_s = isodv_pkg::GP_DEAD;
        endcase
      end
    end

    status.accepted = (wp_s == isodv_pkg::WP_DONE) ||
                      (gp_s == isodv_pkg::GP_TIME_IDLE) ||
                      (gp_s == isodv_pkg::GP_DATE_IDLE && seen_s);
    status.at_start = (gp_r == isodv_pkg::GP_EXPECT_P) && (wp_r == isodv_pkg::WP_START) &&
                      (date_prog_r == 2'd0) && (time_prog_r == 2'd0) && !seen_r;

    gp_nxt        = gp_r;
    wp_nxt        = wp_r;
    date_prog_nxt = date_prog_r;
    time_prog_nxt = time_prog_r;
    seen_nxt      = seen_r;
    if (advance) begin
      if (item.is_last) begin
        gp_nxt        = isodv_pkg::GP_EXPECT_P;
        wp_nxt        = isodv_pkg::WP_START;
        date_prog_nxt = 2'd0;
        time_prog_nxt = 2'd0;
        seen_nxt      = 1'b0;
      end else begin
        gp_nxt        = gp_s;
        wp_nxt        = wp_s;
        date_prog_nxt = date_prog_s;
        time_prog_nxt = time_prog_s;
        seen_nxt      = seen_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r        <= isodv_pkg::GP_EXPECT_P;
      wp_r        <= isodv_pkg::WP_START;
      date_prog_r <= 2'd0;
      time_prog_r <= 2'd0;
      seen_r      <= 1'b0;
    end else begin
      gp_r        <= gp_nxt;
      wp_r        <= wp_nxt;
      date_prog_r <= date_prog_nxt;
      time_prog_r <= time_prog_nxt;
      seen_r      <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iso_duration_validator.sv */
// Top level of the ISO 8601 duration validator: input handshake and result skid buffer.
//
//  channel | direction | payload                                | transfer when
//  in_     | input     | code_unit[15:0], is_last, empty_string  | in_valid & !in_stall
//  out_    | output    | accepted                               | out_valid & !out_stall
//
//  One code unit per cycle while in_stall is low; the recognizer state updates in the cycle of the transfer.
//  An is_last transfer registers its result in the output or, if out_ is held, skid register.
//  Results queue in a two-entry buffer (output register plus skid register);
//  in_stall rises only while both entries hold results.
//  Reset (rst_n low, synchronous) clears the recognizers and empties the buffer.
`default_nettype none
`include "iso_duration_validator_defines.svh"

module iso_duration_validator (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [15:0] in_code_unit,
  input  wire         in_is_last,
  input  wire         in_empty_string,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_accepted
);

  isodv_pkg::item_t   item;
  isodv_pkg::status_t status;
  logic               advance;
  logic               push;
  logic               pop;

  logic out_valid_r, out_valid_nxt;
  logic out_acc_r, out_acc_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_acc_r, skid_acc_nxt;

  assign item.code_unit    = in_code_unit;
  assign item.is_last      = in_is_last;
  assign item.empty_string = in_empty_string;

  assign in_stall = skid_valid_r;
  assign advance  = in_valid && !in_stall;
  assign push     = advance && in_is_last;
  assign pop      = out_valid_r && !out_stall;

  isodv_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .status  (status)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_acc_nxt    = out_acc_r;
    skid_valid_nxt = skid_valid_r;
    skid_acc_nxt   = skid_acc_r;
    if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_acc_nxt    = skid_acc_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_acc_nxt   = status.accepted;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_acc_nxt   = status.accepted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acc_r  <= out_acc_nxt;
    skid_acc_r <= skid_acc_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;

  `ISODV_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `ISODV_ASSERT_NEXT(a_clear_after_last, advance && in_is_last, status.at_start)
  `ISODV_ASSERT_NEXT(a_last_yields_result, push, out_valid_r)

endmodule

`default_nettype wire
